/* hdl/tei_pkg.sv */
// tei_pkg: widths, codes, control/status structs and curve table generators
// for the timed easing interpolator; no dependencies
`default_nettype none

package tei_pkg;

  // sizing of the curve tables and the stored time
  localparam int CURVE_TABLE_DEPTH = 1024;
  localparam int TIME_BITS = 20;

  localparam int TAB_N = CURVE_TABLE_DEPTH - 1;
  localparam int ADDR_W = $clog2(CURVE_TABLE_DEPTH);

  // fixed field widths
  localparam int VALUE_W = 32;
  localparam int DUR_W = 20;
  localparam int ELAPSED_W = 16;
  localparam int CURVE_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Q1.16 progress and shaped progress
  localparam int FRAC_W = 16;
  localparam int S_W = FRAC_W + 1;
  localparam int PROD_W = 2 * S_W;
  localparam logic [S_W-1:0] ONE_Q16 = S_W'(65536);
  localparam logic [S_W-1:0] HALF_Q16 = S_W'(32768);

  // divider runs one quotient bit per step
  localparam int DIV_STEPS = FRAC_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // elapsed-time arithmetic widths
  localparam int SUM_W = ((TIME_BITS > ELAPSED_W) ? TIME_BITS : ELAPSED_W) + 1;
  localparam int CMP_W = (SUM_W > DUR_W) ? SUM_W : DUR_W;

  // input modes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // curve codes
  localparam logic [CURVE_W-1:0] CURVE_LINEAR = 3'd0;
  localparam logic [CURVE_W-1:0] CURVE_EASE = 3'd1;
  localparam logic [CURVE_W-1:0] CURVE_HOLD_A = 3'd2;
  localparam logic [CURVE_W-1:0] CURVE_HOLD_B = 3'd3;
  localparam logic [CURVE_W-1:0] CURVE_POWER = 3'd4;
  localparam logic [CURVE_W-1:0] CURVE_SQUARE = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic div_step;
    logic shape;
    logic rd_lo;
    logic rd_hi;
    logic interp;
    logic mul;
    logic emit;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_last;
  } dp_status_t;

  // power 0.3 entry: largest y with y^10 * N^3 <= i^3 * 2^160
  function automatic logic [S_W-1:0] pow_entry(input int unsigned idx);
    logic [255:0] lhs;
    logic [255:0] rhs;
    logic [S_W-1:0] lo;
    logic [S_W-1:0] hi;
    logic [S_W-1:0] mid;
    rhs = (256'(idx) * 256'(idx) * 256'(idx)) << 160;
    lo = '0;
    hi = ONE_Q16;
    for (int s = 0; s < S_W + 1; s++) begin
      if (lo < hi) begin
        mid = S_W'(((S_W + 1)'(lo) + (S_W + 1)'(hi) + (S_W + 1)'(1)) >> 1);
        lhs = 256'(1);
        for (int k = 0; k < 10; k++) lhs = lhs * 256'(mid);
        for (int k = 0; k < 3; k++) lhs = lhs * 256'(TAB_N);
        if (lhs <= rhs) lo = mid;
        else hi = mid - S_W'(1);
      end
    end
    return lo;
  endfunction

  // sine-squared ease entry: taylor series in Q30, rounded half up to Q16
  function automatic logic [S_W-1:0] ease_entry(input int unsigned idx);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] sq;
    x = (64'd3373259426 * 64'(idx)) / 64'(2 * TAB_N);
    x2 = (x * x) >> 30;
    term = 64'd1073741824;
    term = 64'd1073741824 - ((x2 * term) >> 30) / 64'd156;
    term = 64'd1073741824 - ((x2 * term) >> 30) / 64'd110;
    term = 64'd1073741824 - ((x2 * term) >> 30) / 64'd72;
    term = 64'd1073741824 - ((x2 * term) >> 30) / 64'd42;
    term = 64'd1073741824 - ((x2 * term) >> 30) / 64'd20;
    term = 64'd1073741824 - ((x2 * term) >> 30) / 64'd6;
    s = (x * term) >> 30;
    sq = (s * s) >> 30;
    return S_W'((sq + 64'd8192) >> 14);
  endfunction

endpackage

`default_nettype wire

/* hdl/tei_in_if.sv */
// tei_in_if: command channel (start or tick beats) with valid/ready
// depends on tei_pkg
`default_nettype none

interface tei_in_if import tei_pkg::*; ();
  logic valid;
  logic ready;
  logic mode;
  logic [ELAPSED_W-1:0] elapsed_ms;

  modport source (output valid, output mode, output elapsed_ms, input ready);
  modport sink (input valid, input mode, input elapsed_ms, output ready);
endinterface

`default_nettype wire

/* hdl/tei_out_if.sv */
// tei_out_if: result channel (interpolated value and finished flag)
// depends on tei_pkg
`default_nettype none

interface tei_out_if import tei_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [VALUE_W-1:0] value;
  logic finished;

  modport source (output valid, output value, output finished, input ready);
  modport sink (input valid, input value, input finished, output ready);
endinterface

`default_nettype wire

/* hdl/timed_easing_interpolator.sv */
// timed_easing_interpolator: top level, joins controller and datapath
// depends on tei_pkg, tei_in_if, tei_out_if, tei_ctrl, tei_datapath
//
//   port    | kind              | carries
//   --------+-------------------+-----------------------------------------
//   cmd     | valid/ready sink  | mode (start/tick), elapsed_ms
//   result  | valid/ready source| value (Q16.16), finished
//   cfg_*   | write-only        | start_value, end_value, duration_ms, curve
//
// each beat passes from acceptance to the output register through the
// bit-serial progress divider, then shaping, two table reads,
// interpolation, the output multiply and the final add; the block goes
// back to idle before it can accept a new beat.
// one beat is in flight at a time; a new beat is accepted while the previous
// result still sits in the output register, and the last step waits there
// if that register has not been drained. reset is synchronous, no warm-up.
`default_nettype none

module timed_easing_interpolator import tei_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  tei_in_if.sink                cmd,
  tei_out_if.source             result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctl_cmd_t ctl;
  dp_status_t status;
  logic in_ready;
  logic out_valid;

  assign cmd.ready = in_ready;
  assign result.valid = out_valid;

  // sequencing
  tei_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (result.ready),
    .status    (status),
    .ctl       (ctl)
  );

  // arithmetic and state
  tei_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mode       (cmd.mode),
    .elapsed_ms (cmd.elapsed_ms),
    .value      (result.value),
    .finished   (result.finished)
  );

endmodule

`default_nettype wire

/* hdl/tei_ctrl.sv */
// tei_ctrl: sequencing state machine and output-slot tracking
// depends on tei_pkg
`default_nettype none

module tei_ctrl import tei_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output ctl_cmd_t   ctl
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DIV    = 8'b0000_0010,
    S_SHAPE  = 8'b0000_0100,
    S_RDA    = 8'b0000_1000,
    S_RDB    = 8'b0001_0000,
    S_INTERP = 8'b0010_0000,
    S_MUL    = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic out_full;
  logic accept;
  logic emit;

  assign in_ready = (state == S_IDLE);
  assign accept = in_valid && in_ready;
  // result goes out when the output slot is empty or being drained
  assign emit = (state == S_FIN) && (!out_full || out_ready);
  assign out_valid = out_full;

  // commands
  always_comb begin
    ctl.load = accept;
    ctl.div_step = (state == S_DIV);
    ctl.shape = (state == S_SHAPE);
    ctl.rd_lo = (state == S_RDA);
    ctl.rd_hi = (state == S_RDB);
    ctl.interp = (state == S_INTERP);
    ctl.mul = (state == S_MUL);
    ctl.emit = emit;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_DIV;
      end
      S_DIV: begin
        if (status.div_last) state_next = S_SHAPE;
      end
      S_SHAPE:  state_next = S_RDA;
      S_RDA:    state_next = S_RDB;
      S_RDB:    state_next = S_INTERP;
      S_INTERP: state_next = S_MUL;
      S_MUL:    state_next = S_FIN;
      S_FIN: begin
        if (emit) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // state and output slot
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) out_full <= 1'b1;
      else if (out_ready) out_full <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* hdl/tei_datapath.sv */
// tei_datapath: config registers, time accumulation, bit-serial progress
// divider, curve tables and output arithmetic; depends on tei_pkg
`default_nettype none

module tei_datapath import tei_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  ctl_cmd_t                     ctl,
  output dp_status_t                   status,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         mode,
  input  logic [ELAPSED_W-1:0]         elapsed_ms,
  output logic signed [VALUE_W-1:0]    value,
  output logic                         finished
);

  localparam int P_W = S_W + 1 + VALUE_W + 1;
  localparam logic [CMP_W-1:0] TIME_MAX = CMP_W'((64'd1 << TIME_BITS) - 64'd1);

  // configuration and architectural state
  logic signed [VALUE_W-1:0] start_value;
  logic signed [VALUE_W-1:0] end_value;
  logic [DUR_W-1:0] duration_ms;
  logic [CURVE_W-1:0] curve;
  logic [TIME_BITS-1:0] time_so_far;
  logic done_flag;

  // work registers
  logic [DUR_W-1:0] rem;
  logic [FRAC_W-1:0] quo;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic t_full;
  logic signed [VALUE_W:0] diff_q;
  logic [S_W-1:0] t_q;
  logic [PROD_W-1:0] prod;
  logic [S_W-1:0] rd_q;
  logic [S_W-1:0] a_q;
  logic [S_W-1:0] shaped;
  logic signed [P_W-1:0] p_q;

  // curve tables, built at elaboration
  logic [S_W-1:0] pow_rom [CURVE_TABLE_DEPTH];
  logic [S_W-1:0] ease_rom [CURVE_TABLE_DEPTH];

  for (genvar gi = 0; gi < CURVE_TABLE_DEPTH; gi++) begin : g_rom
    localparam logic [S_W-1:0] PowVal = pow_entry(gi);
    localparam logic [S_W-1:0] EaseVal = ease_entry(gi);
    assign pow_rom[gi] = PowVal;
    assign ease_rom[gi] = EaseVal;
  end

  // time update on a new beat
  logic [CMP_W-1:0] sum_ext;
  logic [CMP_W-1:0] dur_ext;
  logic [CMP_W-1:0] tm_raw;
  logic [CMP_W-1:0] tm_clamp;
  logic [CMP_W-1:0] tm_sat;
  logic over;

  always_comb begin
    sum_ext = CMP_W'(time_so_far) + CMP_W'(elapsed_ms);
    dur_ext = CMP_W'(duration_ms);
    tm_raw = (mode == MODE_START) ? '0 : sum_ext;
    over = tm_raw > dur_ext;
    tm_clamp = over ? dur_ext : tm_raw;
    tm_sat = (tm_clamp > TIME_MAX) ? TIME_MAX : tm_clamp;
  end

  // one restoring divide step
  logic [DUR_W:0] rem2;
  logic div_ge;

  always_comb begin
    rem2 = {rem, 1'b0};
    div_ge = rem2 >= {1'b0, duration_ms};
  end

  assign status.div_last = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));

  // progress, folded progress and multiplier operands
  logic [S_W-1:0] t_val;
  logic [S_W-1:0] u_val;
  logic [S_W-1:0] mul_a;
  logic [S_W-1:0] mul_b;

  always_comb begin
    t_val = t_full ? ONE_Q16 : {1'b0, quo};
    u_val = (t_val <= HALF_Q16) ? t_val : ONE_Q16 - t_val;
    if (curve == CURVE_EASE) begin
      mul_a = u_val;
      mul_b = S_W'(2 * TAB_N);
    end else if (curve == CURVE_SQUARE) begin
      mul_a = t_val;
      mul_b = t_val;
    end else begin
      mul_a = t_val;
      mul_b = S_W'(TAB_N);
    end
  end

  // table address from the scaled position
  logic [PROD_W-FRAC_W-1:0] k_full;
  logic [FRAC_W-1:0] frac;
  logic clamp;
  logic [ADDR_W-1:0] k_addr;
  logic [ADDR_W-1:0] rom_addr;

  always_comb begin
    k_full = prod[PROD_W-1:FRAC_W];
    frac = prod[FRAC_W-1:0];
    clamp = k_full >= (PROD_W - FRAC_W)'(TAB_N);
    k_addr = clamp ? ADDR_W'(TAB_N) : k_full[ADDR_W-1:0];
    if (ctl.rd_hi && !clamp) rom_addr = k_addr + ADDR_W'(1);
    else rom_addr = k_addr;
  end

  // interpolation between neighboring entries
  logic up;
  logic [S_W-1:0] dmag;
  logic [S_W+FRAC_W-1:0] dprod;
  logic [S_W+FRAC_W:0] dprod_up;
  logic [S_W-1:0] interp;

  always_comb begin
    up = rd_q >= a_q;
    dmag = up ? rd_q - a_q : a_q - rd_q;
    dprod = (S_W + FRAC_W)'(dmag) * (S_W + FRAC_W)'(frac);
    dprod_up = (S_W + FRAC_W + 1)'(dprod) + (S_W + FRAC_W + 1)'(16'hFFFF);
    if (clamp) interp = a_q;
    else if (up) interp = a_q + dprod[S_W+FRAC_W-1:FRAC_W];
    else interp = a_q - dprod_up[S_W+FRAC_W-1:FRAC_W];
  end

  // config writes and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      start_value <= '0;
      end_value <= '0;
      duration_ms <= '0;
      curve <= CURVE_LINEAR;
      time_so_far <= '0;
      done_flag <= 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START:    start_value <= cfg_data[VALUE_W-1:0];
          REG_END:      end_value <= cfg_data[VALUE_W-1:0];
          REG_DURATION: duration_ms <= cfg_data[DUR_W-1:0];
          REG_CURVE: begin
            // curve locked while a run is in progress
            if (done_flag && cfg_data[CURVE_W-1:0] <= CURVE_SQUARE)
              curve <= cfg_data[CURVE_W-1:0];
          end
          default: ;
        endcase
      end
      if (ctl.load) begin
        time_so_far <= tm_sat[TIME_BITS-1:0];
        if (over) done_flag <= 1'b1;
        else if (mode == MODE_START) done_flag <= 1'b0;
      end
    end
  end

  // divider counter
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (ctl.load) begin
      div_cnt <= '0;
    end else if (ctl.div_step) begin
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  // datapath work registers
  always_ff @(posedge clk) begin
    // table read, registered every cycle
    rd_q <= (curve == CURVE_EASE) ? ease_rom[rom_addr] : pow_rom[rom_addr];

    if (ctl.load) begin
      rem <= tm_sat[DUR_W-1:0];
      quo <= '0;
      t_full <= (duration_ms == '0) || (tm_sat >= dur_ext);
      diff_q <= (VALUE_W + 1)'(end_value) - (VALUE_W + 1)'(start_value);
    end
    if (ctl.div_step) begin
      rem <= div_ge ? DUR_W'(rem2 - {1'b0, duration_ms}) : rem2[DUR_W-1:0];
      quo <= {quo[FRAC_W-2:0], div_ge};
    end
    if (ctl.shape) begin
      t_q <= t_val;
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (ctl.rd_hi) begin
      a_q <= rd_q;
    end
    if (ctl.interp) begin
      case (curve)
        CURVE_EASE:   shaped <= interp;
        CURVE_POWER:  shaped <= interp;
        CURVE_HOLD_A: shaped <= '0;
        CURVE_HOLD_B: shaped <= ONE_Q16;
        CURVE_SQUARE: shaped <= prod[FRAC_W+S_W-1:FRAC_W];
        default:      shaped <= t_q;
      endcase
    end
    if (ctl.mul) begin
      p_q <= $signed({1'b0, shaped}) * diff_q;
    end
    // floor of the scaled product is an arithmetic shift
    if (ctl.emit) begin
      value <= start_value + p_q[FRAC_W+VALUE_W-1:FRAC_W];
      finished <= done_flag;
    end
  end

endmodule

`default_nettype wire

/* bench/timed_easing_interpolator_test.sv */
// timed_easing_interpolator_test: self-checking bench for the tween generator,
// random start/tick beats checked against an in-bench fixed-point predictor
// depends on tei_pkg, tei_in_if, tei_out_if and timed_easing_interpolator
`default_nettype none

module timed_easing_interpolator_test import tei_pkg::*; ();

  typedef struct packed {
    logic mode;
    logic [ELAPSED_W-1:0] elapsed;
  } tween_cmd_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic finished;
  } tween_res_t;

  localparam longint unsigned TIME_MAX = (64'd1 << TIME_BITS) - 64'd1;
  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  // a curve code the block must refuse
  localparam logic [CURVE_W-1:0] CURVE_BAD = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tei_in_if cmd_ch ();
  tei_out_if res_ch ();

  timed_easing_interpolator i_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .result(res_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // curve tables and predictor state
  int unsigned pow_rom [CURVE_TABLE_DEPTH];
  int unsigned ease_rom [CURVE_TABLE_DEPTH];
  logic signed [VALUE_W-1:0] start_reg;
  logic signed [VALUE_W-1:0] end_reg;
  logic [DUR_W-1:0] dur_reg;
  logic [CURVE_W-1:0] curve_reg;
  logic [TIME_BITS-1:0] time_acc;
  logic idle_flag;

  tween_cmd_t cmd_backlog [$];
  tween_res_t tween_expect_q [$];
  tween_res_t due_res;

  int burst_left = 0;
  int gap_left = 0;
  bit sender_gaps = 1'b1;
  int item_count = 0;
  int mismatches = 0;
  int hold_left = 0;
  int stall_pct = 0;
  int pattern_cnt = 0;
  bit long_hold_req = 1'b0;
  bit long_hold_taken = 1'b0;

  // exact test for y <= 65536 * (idx/N)^0.3: y^10 * N^3 <= idx^3 * 2^160
  function automatic bit pow_fits(input int unsigned y, input int unsigned idx);
    logic [255:0] y5;
    logic [255:0] lhs;
    logic [255:0] rhs;
    y5 = 256'(y) * 256'(y) * 256'(y) * 256'(y) * 256'(y);
    lhs = y5 * y5 * 256'(TAB_N) * 256'(TAB_N) * 256'(TAB_N);
    rhs = (256'(idx) * 256'(idx) * 256'(idx)) << 160;
    return lhs <= rhs;
  endfunction

  // sample a table with linear interpolation between neighbors
  function automatic longint unsigned curve_rom_read(input bit ease_sel,
                                                     input longint unsigned pos);
    longint unsigned k;
    longint unsigned f;
    longint unsigned a;
    longint unsigned b;
    k = pos >> FRAC_W;
    if (k >= TAB_N) return ease_sel ? ease_rom[TAB_N] : pow_rom[TAB_N];
    f = pos & 64'hFFFF;
    a = ease_sel ? ease_rom[k] : pow_rom[k];
    b = ease_sel ? ease_rom[k + 1] : pow_rom[k + 1];
    if (b >= a) return a + (((b - a) * f) >> FRAC_W);
    return a - (((a - b) * f + 64'hFFFF) >> FRAC_W);
  endfunction

  // advance time, shape progress and interpolate for one accepted beat
  function automatic tween_res_t tween_predict(input logic mode,
                                               input logic [ELAPSED_W-1:0] elapsed);
    longint unsigned tm;
    longint unsigned progress;
    longint unsigned fold;
    longint unsigned shaped;
    longint prod;
    tween_res_t r;
    if (mode == MODE_START) begin
      tm = 0;
      idle_flag = 1'b0;
    end else begin
      tm = longint'(time_acc) + longint'(elapsed);
    end
    if (tm > dur_reg) begin
      tm = dur_reg;
      idle_flag = 1'b1;
    end
    if (tm > TIME_MAX) tm = TIME_MAX;
    time_acc = TIME_BITS'(tm);
    if (dur_reg == 0 || tm >= dur_reg) progress = ONE_Q16;
    else progress = (tm << FRAC_W) / dur_reg;
    case (curve_reg)
      CURVE_EASE: begin
        fold = (progress <= HALF_Q16) ? progress : ONE_Q16 - progress;
        shaped = curve_rom_read(1'b1, fold * 2 * TAB_N);
      end
      CURVE_HOLD_A: shaped = 0;
      CURVE_HOLD_B: shaped = ONE_Q16;
      CURVE_POWER: shaped = curve_rom_read(1'b0, progress * TAB_N);
      CURVE_SQUARE: shaped = (progress * progress) >> FRAC_W;
      default: shaped = progress;
    endcase
    prod = longint'(shaped) * (longint'(end_reg) - longint'(start_reg));
    r.value = VALUE_W'(longint'(start_reg) + (prod >>> FRAC_W));
    r.finished = idle_flag;
    return r;
  endfunction

  // Q16.16 value biased toward the extremes
  function automatic logic [CFG_DATA_W-1:0] pick_q16();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic void enqueue_cmd(input logic mode, input logic [ELAPSED_W-1:0] el);
    tween_cmd_t c;
    c.mode = mode;
    c.elapsed = el;
    cmd_backlog.push_back(c);
    item_count++;
  endfunction

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || tween_expect_q.size() != 0) @(posedge clk);
  endtask

  // one register write, mirrored into the predictor at the write edge
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_START: start_reg = data;
      REG_END: end_reg = data;
      REG_DURATION: dur_reg = data[DUR_W-1:0];
      REG_CURVE: begin
        if (idle_flag && data[CURVE_W-1:0] <= CURVE_SQUARE) curve_reg = data[CURVE_W-1:0];
      end
      default: ;
    endcase
  endtask

  // build the power and sine-squared tables
  initial begin : build_curve_roms
    logic [63:0] ang;
    logic [63:0] ang2;
    logic [63:0] acc;
    logic [63:0] sn;
    logic [63:0] sq;
    int unsigned y;
    for (int i = 0; i < CURVE_TABLE_DEPTH; i++) begin
      // float guess, then settle on the exact floor
      y = $rtoi(65536.0 * ((real'(i) / real'(TAB_N)) ** 0.3));
      while (y > 0 && !pow_fits(y, i)) y--;
      while (y < 65536 && pow_fits(y + 1, i)) y++;
      pow_rom[i] = y;
      // sin(x) by horner over the taylor terms up to x^13, in Q30
      ang = (PI_Q30 * 64'(i)) / 64'(2 * TAB_N);
      ang2 = (ang * ang) >> 30;
      acc = Q30_ONE;
      for (int j = 6; j >= 1; j--) begin
        acc = Q30_ONE - ((ang2 * acc) >> 30) / 64'((2 * j) * (2 * j + 1));
      end
      sn = (ang * acc) >> 30;
      sq = (sn * sn) >> 30;
      ease_rom[i] = 32'((sq + 64'd8192) >> 14);
    end
  end

  // command driver: bursts of beats with random gaps
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        tween_expect_q.push_back(tween_predict(cmd_ch.mode, cmd_ch.elapsed_ms));
        void'(cmd_backlog.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = sender_gaps ? $urandom_range(1, 15) : 0;
        end
      end else if (!cmd_ch.valid && gap_left > 0) begin
        gap_left--;
      end
      // an offered beat stays put until taken
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (gap_left == 0 && cmd_backlog.size() != 0) begin
          cmd_ch.valid <= 1'b1;
          cmd_ch.mode <= cmd_backlog[0].mode;
          cmd_ch.elapsed_ms <= cmd_backlog[0].elapsed;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (tween_expect_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat, expected none, got value %h finished %b",
                   $time, res_ch.value, res_ch.finished);
        end else begin
          due_res = tween_expect_q.pop_front();
          if (res_ch.value !== due_res.value) begin
            mismatches++;
            $display("%0t: value mismatch, expected %h, got %h",
                     $time, due_res.value, res_ch.value);
          end
          if (res_ch.finished !== due_res.finished) begin
            mismatches++;
            $display("%0t: finished mismatch, expected %b, got %b",
                     $time, due_res.finished, res_ch.finished);
          end
        end
      end
      // one long hold-off on request, otherwise a changing stall density
      if (long_hold_req && !long_hold_taken) begin
        hold_left = 400;
        long_hold_taken = 1'b1;
      end
      pattern_cnt++;
      if (pattern_cnt % 300 == 0) stall_pct = $urandom_range(0, 3) * 28;
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    int n;
    int phase;
    int run_left;
    longint unsigned step;
    longint unsigned el;
    int unsigned c;
    int unsigned d;
    cmd_ch.valid = 1'b0;
    cmd_ch.mode = MODE_START;
    cmd_ch.elapsed_ms = '0;
    res_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_START;
    cfg_data = '0;
    start_reg = '0;
    end_reg = '0;
    dur_reg = '0;
    curve_reg = CURVE_LINEAR;
    time_acc = '0;
    idle_flag = 1'b1;
    run_left = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // tick before any start, zero duration
    enqueue_cmd(MODE_TICK, 16'hFFFF);
    wait_drained();
    set_reg(REG_START, 32'h8000_0000);
    set_reg(REG_END, 32'h7FFF_FFFF);
    set_reg(REG_DURATION, 32'd1000);
    set_reg(REG_CURVE, 32'(CURVE_LINEAR));
    // landing on the duration exactly keeps finished low, one more ms sets it
    enqueue_cmd(MODE_START, 16'h0000);
    enqueue_cmd(MODE_TICK, 16'd500);
    enqueue_cmd(MODE_TICK, 16'd500);
    enqueue_cmd(MODE_TICK, 16'd1);
    // curve write mid-run is dropped, shorter duration clamps the next tick
    enqueue_cmd(MODE_START, 16'hFFFF);
    enqueue_cmd(MODE_TICK, 16'd300);
    wait_drained();
    set_reg(REG_CURVE, 32'(CURVE_POWER));
    set_reg(REG_DURATION, 32'd200);
    enqueue_cmd(MODE_TICK, 16'd0);
    wait_drained();
    // out-of-range curve code is dropped
    set_reg(REG_CURVE, 32'(CURVE_BAD));
    enqueue_cmd(MODE_START, 16'd0);
    enqueue_cmd(MODE_TICK, 16'd100);
    enqueue_cmd(MODE_TICK, 16'd200);
    wait_drained();
    set_reg(REG_CURVE, 32'(CURVE_EASE));
    enqueue_cmd(MODE_START, 16'd0);
    enqueue_cmd(MODE_TICK, 16'd50);
    enqueue_cmd(MODE_TICK, 16'd50);
    enqueue_cmd(MODE_TICK, 16'd101);
    wait_drained();
    set_reg(REG_CURVE, 32'(CURVE_HOLD_A));
    set_reg(REG_START, 32'h7FFF_FFFF);
    set_reg(REG_END, 32'h8000_0000);
    enqueue_cmd(MODE_START, 16'd0);
    enqueue_cmd(MODE_TICK, 16'hFFFF);
    wait_drained();
    set_reg(REG_CURVE, 32'(CURVE_HOLD_B));
    enqueue_cmd(MODE_START, 16'd0);
    enqueue_cmd(MODE_TICK, 16'hFFFF);
    wait_drained();
    // longest duration, upper data bits set
    set_reg(REG_CURVE, 32'(CURVE_POWER));
    set_reg(REG_DURATION, 32'hFFFF_FFFF);
    enqueue_cmd(MODE_START, 16'd0);
    enqueue_cmd(MODE_TICK, 16'hFFFF);
    enqueue_cmd(MODE_TICK, 16'd1);
    wait_drained();
    set_reg(REG_DURATION, 32'd0);
    enqueue_cmd(MODE_TICK, 16'd0);
    wait_drained();
    // start on a zero duration leaves finished low; endpoints change mid-run
    set_reg(REG_CURVE, 32'(CURVE_SQUARE));
    enqueue_cmd(MODE_START, 16'd0);
    wait_drained();
    set_reg(REG_START, 32'h0001_2345);
    enqueue_cmd(MODE_TICK, 16'd7);

    // random phases: mostly start-then-ticks runs, some noise beats
    phase = 0;
    while (item_count < 1275) begin
      phase++;
      wait_drained();
      if ($urandom_range(0, 3) != 0) set_reg(REG_START, pick_q16());
      if ($urandom_range(0, 3) != 0) set_reg(REG_END, pick_q16());
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0: d = 0;
          1: d = 20'hFFFFF;
          2, 3, 4: d = $urandom_range(1, 40);
          5, 6, 7: d = $urandom_range(41, 20000);
          default: d = $urandom_range(20001, 20'hFFFFF);
        endcase
        set_reg(REG_DURATION, {12'($urandom()), 20'(d)});
      end
      if ($urandom_range(0, 3) != 0) begin
        c = $urandom_range(0, 7);
        set_reg(REG_CURVE, ($urandom_range(0, 3) == 0) ? {29'($urandom()), 3'(c)} : 32'(c));
      end
      sender_gaps = (phase % 5 != 0) && (phase != 3);
      if (phase == 3) long_hold_req = 1'b1;
      n = $urandom_range(15, 45);
      for (int j = 0; j < n; j++) begin
        // pause the sender until every result is back
        if (phase % 6 == 2 && j == n / 2) wait_drained();
        if ($urandom_range(0, 9) == 0) begin
          enqueue_cmd(1'($urandom()), 16'($urandom()));
        end else if (run_left == 0) begin
          enqueue_cmd(MODE_START, 16'($urandom()));
          run_left = $urandom_range(2, 20);
          step = dur_reg / run_left;
        end else begin
          el = step + $urandom_range(0, 2);
          if (el > 16'hFFFF) el = 16'hFFFF;
          enqueue_cmd(MODE_TICK, 16'(el));
          run_left--;
        end
      end
      // often close out the run so curve writes take effect
      if ($urandom_range(0, 1) == 0) begin
        enqueue_cmd(MODE_TICK, 16'hFFFF);
        run_left = 0;
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("timed_easing_interpolator_test passed");
    end else begin
      $display("timed_easing_interpolator_test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("timed_easing_interpolator_test failed");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
hdl/tei_pkg.sv
hdl/tei_in_if.sv
hdl/tei_out_if.sv
hdl/tei_ctrl.sv
hdl/tei_datapath.sv
hdl/timed_easing_interpolator.sv
bench/timed_easing_interpolator_test.sv
